// ===== rtl/mdi_pkg.sv =====
package mdi_pkg;

  localparam int DataW = 32;
  localparam int AccW  = 52;
  localparam int DivW  = 49;

  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quo;
  } div_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [AccW-1:0] v);
    logic signed [AccW-1:0] hi;
    logic signed [AccW-1:0] lo;
    hi = $signed({{(AccW-32){1'b0}}, 32'h7fffffff});
    lo = $signed({{(AccW-32){1'b1}}, 32'h80000000});
    if (v > hi) begin
      return 32'sh7fffffff;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return 32'(v);
  endfunction

endpackage

// ===== rtl/mdi_if.sv =====
interface mdi_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element_value;

  modport source (output valid, output element_value, input ready);
  modport sink (input valid, input element_value, output ready);
endinterface

interface mdi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_value;
  logic signed [31:0] determinant_value;
  logic               is_singular;
  logic               is_last;

  modport source (output valid, output inverse_value, output determinant_value,
                  output is_singular, output is_last, input ready);
  modport sink (input valid, input inverse_value, input determinant_value,
                input is_singular, input is_last, output ready);
endinterface

// ===== rtl/matrix_determinant_inverse_top.sv =====
// Channel | Dir | Fields                                        | Use
// elem_i  | in  | element_value                                 | matrix, row-major
// inv_o   | out | inverse_value determinant_value is_singular   | inverse, row-major
//         |     | is_last                                       |
// Loading accepts one element per cycle. After the last element the minor table is
// built in the work memory, one row/column term at a time (read, multiply,
// accumulate). Each of the DIM*DIM quotients is then computed in the bit-serial
// divider and emitted as one transfer.
// Input is not taken while a matrix is computed or emitted; output stalls hold it.
// Reset clears control state only; memory contents stay undefined.
module matrix_determinant_inverse_top #(
  parameter int DIM = 3
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mdi_in_if.sink           elem_i,
  mdi_out_if.source        inv_o
);

  localparam int NE   = DIM * DIM;
  localparam int EW   = $clog2(NE);
  localparam int CNTW = $clog2(NE + 1);
  localparam int NM   = 1 << DIM;
  localparam int WA   = $clog2(NM + NE);
  localparam int CW   = (DIM > 2) ? $clog2(DIM) : 1;
  localparam int PW   = $clog2(DIM + 1);
  localparam int AW   = mdi_pkg::AccW;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_RD   = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_ACC  = 4'd4;
  localparam logic [3:0] S_WR   = 4'd5;
  localparam logic [3:0] S_ARD  = 4'd6;
  localparam logic [3:0] S_AWT  = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]             state_q;
  logic [CNTW-1:0]        cnt_q;
  logic [PW-1:0]          pass_q, lvl_q;
  logic [DIM-1:0]         mask_q;
  logic [CW-1:0]          col_q;
  logic                   rank_q;
  logic signed [AW-1:0]   acc_q;
  logic signed [63:0]     prod_q;
  logic signed [31:0]     det_q, inv_q;
  logic [EW-1:0]          k_q;

  logic signed [31:0]     mat_mem [NE];
  logic signed [31:0]     wrk_mem [NM+NE];
  logic signed [31:0]     mat_rd_q, wrk_rd_q;

  logic                   in_fire;
  logic [PW-1:0]          n_lvl, p_row, row;
  logic [EW-1:0]          maddr;
  logic [WA-1:0]          waddr_rd, waddr_wr;
  logic                   wr_en;
  logic signed [31:0]     wr_data, val, cof;
  logic [PW-1:0]          pop;
  logic [CW-1:0]          low_col, nxt_col, miss_col;
  logic                   has_nxt;
  logic signed [63:0]     rnd;
  logic signed [AW-1:0]   term;
  logic                   adv_pass_end;
  logic [DIM-1:0]         adv_mask;
  logic [PW-1:0]          adv_lvl;
  mdi_pkg::div_req_t      div_req;
  mdi_pkg::div_rsp_t      div_rsp;

  assign in_fire = elem_i.valid && elem_i.ready;

  always_comb begin
    n_lvl = (pass_q == PW'(DIM)) ? PW'(DIM) : PW'(DIM - 1);
    p_row = n_lvl - lvl_q;
    row   = ((pass_q == PW'(DIM)) || (p_row < pass_q)) ? p_row : p_row + PW'(1);
    maddr = EW'(int'(row) * DIM + int'(col_q));

    pop      = '0;
    low_col  = '0;
    nxt_col  = '0;
    miss_col = '0;
    has_nxt  = 1'b0;
    for (int c = DIM - 1; c >= 0; c--) begin
      pop = pop + PW'(mask_q[c]);
      if (mask_q[c]) low_col = CW'(c);
      if (!mask_q[c]) miss_col = CW'(c);
      if (mask_q[c] && (CW'(c) > col_q)) begin
        nxt_col = CW'(c);
        has_nxt = 1'b1;
      end
    end

    rnd  = prod_q + 64'sd32768;
    term = AW'($signed(rnd[63:16]));
    val  = mdi_pkg::sat32(acc_q);
    cof  = (pass_q[0] ^ miss_col[0]) ? mdi_pkg::sat32(-AW'(val)) : val;

    adv_pass_end = 1'b0;
    adv_mask     = mask_q + DIM'(1);
    adv_lvl      = lvl_q;
    if (&mask_q) begin
      adv_mask = DIM'(1);
      if (lvl_q != n_lvl) begin
        adv_lvl = lvl_q + PW'(1);
      end else begin
        adv_lvl      = PW'(1);
        adv_pass_end = 1'b1;
      end
    end

    if (state_q == S_ARD) begin
      waddr_rd = WA'(NM + int'(k_q));
    end else begin
      waddr_rd = WA'(mask_q & ~(DIM'(1) << col_q));
    end

    wr_en    = 1'b0;
    waddr_wr = WA'(mask_q);
    wr_data  = val;
    if (state_q == S_WR) begin
      if (lvl_q != n_lvl) begin
        wr_en = 1'b1;
      end else if (pass_q != PW'(DIM)) begin
        wr_en    = 1'b1;
        waddr_wr = WA'(NM + int'(miss_col) * DIM + int'(pass_q));
        wr_data  = cof;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) mat_mem[cnt_q[EW-1:0]] <= elem_i.element_value;
    mat_rd_q <= mat_mem[maddr];
    if (wr_en) wrk_mem[waddr_wr] <= wr_data;
    wrk_rd_q <= wrk_mem[waddr_rd];
  end

  always_comb begin
    div_req.start = (state_q == S_AWT);
    div_req.num   = wrk_rd_q;
    div_req.den   = det_q;
  end

  mdi_divider u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      pass_q  <= '0;
      lvl_q   <= '0;
      mask_q  <= '0;
      col_q   <= '0;
      rank_q  <= 1'b0;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_LOAD: begin
          if (in_fire) begin
            if (cnt_q == CNTW'(NE - 1)) begin
              cnt_q   <= '0;
              pass_q  <= PW'(DIM);
              lvl_q   <= PW'(1);
              mask_q  <= DIM'(1);
              state_q <= S_SCAN;
            end else begin
              cnt_q <= cnt_q + CNTW'(1);
            end
          end
        end
        S_SCAN: begin
          if (pop == lvl_q) begin
            col_q   <= low_col;
            rank_q  <= 1'b0;
            state_q <= S_RD;
          end else begin
            mask_q <= adv_mask;
            lvl_q  <= adv_lvl;
            if (adv_pass_end) begin
              if (pass_q == PW'(DIM - 1)) begin
                k_q     <= '0;
                state_q <= S_ARD;
              end else begin
                pass_q <= pass_q + PW'(1);
              end
            end
          end
        end
        S_RD:  state_q <= S_MUL;
        S_MUL: state_q <= (lvl_q == PW'(1)) ? S_WR : S_ACC;
        S_ACC: begin
          if (has_nxt) begin
            col_q   <= nxt_col;
            rank_q  <= ~rank_q;
            state_q <= S_RD;
          end else begin
            state_q <= S_WR;
          end
        end
        S_WR: begin
          mask_q  <= adv_mask;
          lvl_q   <= adv_lvl;
          state_q <= S_SCAN;
          if (adv_pass_end) begin
            if (pass_q == PW'(DIM)) begin
              pass_q <= '0;
            end else if (pass_q == PW'(DIM - 1)) begin
              k_q     <= '0;
              state_q <= S_ARD;
            end else begin
              pass_q <= pass_q + PW'(1);
            end
          end
        end
        S_ARD: state_q <= S_AWT;
        S_AWT: state_q <= S_DIV;
        S_DIV: begin
          if (div_rsp.done) state_q <= S_OUT;
        end
        S_OUT: begin
          if (inv_o.ready) begin
            if (k_q == EW'(NE - 1)) begin
              state_q <= S_LOAD;
            end else begin
              k_q     <= k_q + EW'(1);
              state_q <= S_ARD;
            end
          end
        end
        default: state_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_SCAN) acc_q <= '0;
    if (state_q == S_MUL) begin
      if (lvl_q == PW'(1)) acc_q <= AW'(mat_rd_q);
      else prod_q <= mat_rd_q * wrk_rd_q;
    end
    if (state_q == S_ACC) acc_q <= rank_q ? (acc_q - term) : (acc_q + term);
    if ((state_q == S_WR) && (lvl_q == n_lvl) && (pass_q == PW'(DIM))) det_q <= val;
    if ((state_q == S_DIV) && div_rsp.done) inv_q <= div_rsp.quo;
  end

  assign elem_i.ready            = (state_q == S_LOAD);
  assign inv_o.valid             = (state_q == S_OUT);
  assign inv_o.inverse_value     = inv_q;
  assign inv_o.determinant_value = det_q;
  assign inv_o.is_singular       = (det_q == 32'sd0);
  assign inv_o.is_last           = (k_q == EW'(NE - 1));

endmodule

// ===== rtl/mdi_divider.sv =====
module mdi_divider (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mdi_pkg::div_req_t req_i,
  output mdi_pkg::div_rsp_t rsp_o
);

  localparam int NW = mdi_pkg::DivW;
  localparam int CW = $clog2(NW);

  logic          busy_q, done_q, neg_q, zero_q;
  logic [CW-1:0] cnt_q;
  logic [NW-1:0] n_q, q_q;
  logic [31:0]   rem_q, ud_q;

  logic [31:0]   nmag, dmag;
  logic [NW-1:0] nstart;
  logic [32:0]   r2;
  logic          ge;

  always_comb begin
    nmag   = req_i.num[31] ? (~req_i.num + 32'd1) : req_i.num;
    dmag   = req_i.den[31] ? (~req_i.den + 32'd1) : req_i.den;
    nstart = {1'b0, nmag, 16'b0} + NW'(dmag >> 1);
    r2     = {rem_q, n_q[NW-1]};
    ge     = r2 >= {1'b0, ud_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW-1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      n_q    <= nstart;
      ud_q   <= dmag;
      rem_q  <= '0;
      q_q    <= '0;
      neg_q  <= req_i.num[31] ^ req_i.den[31];
      zero_q <= (dmag == 32'd0);
    end else if (busy_q) begin
      n_q   <= {n_q[NW-2:0], 1'b0};
      rem_q <= ge ? 32'(r2 - {1'b0, ud_q}) : r2[31:0];
      q_q   <= {q_q[NW-2:0], ge};
    end
  end

  always_comb begin
    rsp_o.done = done_q;
    if (zero_q) begin
      rsp_o.quo = '0;
    end else if (!neg_q) begin
      rsp_o.quo = (q_q > NW'(32'h7fffffff)) ? 32'sh7fffffff : $signed(q_q[31:0]);
    end else begin
      rsp_o.quo = (q_q > NW'(32'h80000000)) ? 32'sh80000000 : $signed(32'(~q_q[31:0] + 32'd1));
    end
  end

endmodule

// ===== rtl/mdi_checker.sv =====
module mdi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] inv_i,
  input logic [31:0] det_i,
  input logic        sing_i,
  input logic        last_i
);

  ap_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !in_ready_i) else $error("load open while emitting");

  ap_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && sing_i) |-> (inv_i == 32'd0)) else $error("singular inverse not zero");

  ap_sing_det: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (sing_i == (det_i == 32'd0))) else $error("singular flag mismatch");

  ap_mid_matrix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && out_ready_i && !last_i) |=> !in_ready_i)
    else $error("load before last transfer");

  ap_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(inv_i) && $stable(last_i)))
    else $error("stalled output changed");

endmodule

bind matrix_determinant_inverse_top mdi_checker u_mdi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (elem_i.ready),
  .out_valid_i (inv_o.valid),
  .out_ready_i (inv_o.ready),
  .inv_i       (inv_o.inverse_value),
  .det_i       (inv_o.determinant_value),
  .sing_i      (inv_o.is_singular),
  .last_i      (inv_o.is_last)
);
